>>> rtl/core/ipp_pkg.sv
// Package for the isometric point-to-pixel mapper: payload structs, the
// configuration set, the queue entry and fixed projection constants.
// No dependencies.
package ipp_pkg;

   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 64;
   localparam int FIFO_DEPTH    = 8;
   localparam int QUOT_BITS     = 7;
   localparam int NUM_BITS      = 40;

   // Q0.16 projection weights, rounded to nearest
   localparam logic signed [16:0] K_ONE   = 17'sd46341;
   localparam logic signed [16:0] K_TWO   = 17'sd53510;
   localparam logic signed [16:0] K_THREE = 17'sd26755;

   // Register indexes
   localparam logic [7:0] REG_VIEW_MIN_X    = 8'd0;
   localparam logic [7:0] REG_VIEW_MAX_X    = 8'd1;
   localparam logic [7:0] REG_VIEW_MIN_Y    = 8'd2;
   localparam logic [7:0] REG_VIEW_MAX_Y    = 8'd3;
   localparam logic [7:0] REG_SCREEN_LEFT   = 8'd4;
   localparam logic [7:0] REG_SCREEN_TOP    = 8'd5;
   localparam logic [7:0] REG_SCREEN_RIGHT  = 8'd6;
   localparam logic [7:0] REG_SCREEN_BOTTOM = 8'd7;

   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic signed [15:0] point_z;
      logic               eval_error;
   } req_type;

   typedef struct packed {
      logic [6:0] pixel_col;
      logic [5:0] pixel_row;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] view_min_x;
      logic signed [15:0] view_max_x;
      logic signed [15:0] view_min_y;
      logic signed [15:0] view_max_y;
      logic [6:0]         screen_left;
      logic [5:0]         screen_top;
      logic [6:0]         screen_right;
      logic [5:0]         screen_bottom;
   } cfg_type;

   // One kept sample waiting for its two divisions
   typedef struct packed {
      logic [NUM_BITS-1:0] num_x;
      logic [NUM_BITS-1:0] num_y;
      logic [31:0]         den_x;
      logic [31:0]         den_y;
   } work_type;

   typedef struct packed {
      logic [3:0] count;
      logic       push;
      logic       pop;
   } fifo_status_type;

endpackage

>>> rtl/core/ipp_front.sv
// Front end: accepts samples, projects them, applies the window checks and
// forms the scaled numerators. Depends on ipp_pkg.
module ipp_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  ipp_pkg::req_type req,
   input  ipp_pkg::cfg_type cfg,
   output logic [1:0]      inflight,
   output logic            push,
   output ipp_pkg::work_type work
);
   import ipp_pkg::*;

   // stage 1: products
   logic                v1_ff;
   logic                err_ff;
   logic signed [33:0]  pu_ff, pv1_ff, pv2_ff;
   // stage 2: classified
   logic                v2_ff, v2_in;
   logic [31:0]         du_ff, dv_ff, denx_ff, deny_ff;
   logic [31:0]         du_in, dv_in, denx_in, deny_in;
   logic [6:0]          sw_ff, sw_in;
   logic [5:0]          sh_ff, sh_in;
   // stage 3: numerators
   logic                v3_ff;
   work_type            work_ff, work_in;

   logic signed [16:0]  diff, sum;
   logic signed [34:0]  u, v, lo_x, hi_x, lo_y, hi_y, du, dv;
   logic signed [7:0]   sw;
   logic signed [6:0]   sh;
   logic                drop;

   always_comb begin
      diff = {req.point_x[15], req.point_x} - {req.point_y[15], req.point_y};
      sum  = {req.point_x[15], req.point_x} + {req.point_y[15], req.point_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
      err_ff <= req.eval_error;
      pu_ff  <= 34'(diff * K_ONE);
      pv1_ff <= 34'($signed({req.point_z[15], req.point_z}) * K_TWO);
      pv2_ff <= 34'(sum * K_THREE);
   end

   always_comb begin
      u    = 35'(pu_ff);
      v    = 35'(pv1_ff) - 35'(pv2_ff);
      lo_x = 35'($signed({cfg.view_min_x, 16'b0}));
      hi_x = 35'($signed({cfg.view_max_x, 16'b0}));
      lo_y = 35'($signed({cfg.view_min_y, 16'b0}));
      hi_y = 35'($signed({cfg.view_max_y, 16'b0}));
      sw   = $signed({1'b0, cfg.screen_right}) - $signed({1'b0, cfg.screen_left});
      sh   = $signed({1'b0, cfg.screen_bottom}) - $signed({1'b0, cfg.screen_top});
      du   = u - lo_x;
      dv   = v - lo_y;
      drop = err_ff || (u < lo_x) || (u > hi_x) || (v < lo_y) || (v > hi_y)
             || (hi_x == lo_x) || (hi_y == lo_y) || sw[7] || sh[6];
      v2_in   = v1_ff && !drop;
      du_in   = du[31:0];
      dv_in   = dv[31:0];
      denx_in = 32'(hi_x - lo_x);
      deny_in = 32'(hi_y - lo_y);
      sw_in   = sw[6:0];
      sh_in   = sh[5:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
      end
      du_ff   <= du_in;
      dv_ff   <= dv_in;
      denx_ff <= denx_in;
      deny_ff <= deny_in;
      sw_ff   <= sw_in;
      sh_ff   <= sh_in;
   end

   // row uses a ceiling: fold den_y - 1 into its numerator
   always_comb begin
      work_in.num_x = NUM_BITS'(du_ff * sw_ff);
      work_in.num_y = NUM_BITS'(dv_ff * sh_ff) + NUM_BITS'(deny_ff) - NUM_BITS'(1);
      work_in.den_x = denx_ff;
      work_in.den_y = deny_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      work_ff <= work_in;
   end

   assign inflight = 2'(v1_ff) + 2'(v2_ff) + 2'(v3_ff);
   assign push     = v3_ff;
   assign work     = work_ff;

endmodule

>>> rtl/core/ipp_fifo.sv
// Short queue between front and back ends.
// Depends on ipp_pkg.
module ipp_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ipp_pkg::work_type       wr_data,
   input  logic                    pop,
   output ipp_pkg::work_type       rd_data,
   output logic                    empty,
   output ipp_pkg::fifo_status_type status
);
   import ipp_pkg::*;

   work_type   entry_ff [FIFO_DEPTH];
   logic [2:0] wr_ptr_ff, rd_ptr_ff;
   logic [3:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff + 4'(push) - 4'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 3'd1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 3'd1;
         count_ff <= count_in;
      end
      if (push) entry_ff[wr_ptr_ff] <= wr_data;
   end

   assign rd_data      = entry_ff[rd_ptr_ff];
   assign empty        = (count_ff == 4'd0);
   assign status.count = count_ff;
   assign status.push  = push;
   assign status.pop   = pop;

endmodule

>>> rtl/core/ipp_back.sv
// Back end: pipelined restoring divider for column and row, then the
// output register. Depends on ipp_pkg.
module ipp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              empty,
   input  ipp_pkg::work_type head,
   input  ipp_pkg::cfg_type  cfg,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ipp_pkg::rsp_type  rsp_payload
);
   import ipp_pkg::*;

   logic                 vld_ff  [QUOT_BITS];
   logic [NUM_BITS-1:0]  remx_ff [QUOT_BITS];
   logic [NUM_BITS-1:0]  remy_ff [QUOT_BITS];
   logic [31:0]          denx_ff [QUOT_BITS];
   logic [31:0]          deny_ff [QUOT_BITS];
   logic [QUOT_BITS-1:0] qx_ff   [QUOT_BITS];
   logic [QUOT_BITS-1:0] qy_ff   [QUOT_BITS];

   logic                 vld_in  [QUOT_BITS];
   logic [NUM_BITS-1:0]  remx_in [QUOT_BITS];
   logic [NUM_BITS-1:0]  remy_in [QUOT_BITS];
   logic [31:0]          denx_in [QUOT_BITS];
   logic [31:0]          deny_in [QUOT_BITS];
   logic [QUOT_BITS-1:0] qx_in   [QUOT_BITS];
   logic [QUOT_BITS-1:0] qy_in   [QUOT_BITS];

   logic                 advance;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic [8:0]           col;
   logic [7:0]           row;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && !empty;

   always_comb begin
      for (int k = 0; k < QUOT_BITS; k++) begin
         logic                 sv;
         logic [NUM_BITS-1:0]  rx, ry, tx, ty;
         logic [31:0]          dx, dy;
         logic [QUOT_BITS-1:0] qx, qy;
         if (k == 0) begin
            sv = pop;
            rx = head.num_x;
            ry = head.num_y;
            dx = head.den_x;
            dy = head.den_y;
            qx = '0;
            qy = '0;
         end else begin
            sv = vld_ff[k-1];
            rx = remx_ff[k-1];
            ry = remy_ff[k-1];
            dx = denx_ff[k-1];
            dy = deny_ff[k-1];
            qx = qx_ff[k-1];
            qy = qy_ff[k-1];
         end
         // trial subtract of the divisor at this stage's bit weight
         tx = NUM_BITS'(dx) << (QUOT_BITS - 1 - k);
         ty = NUM_BITS'(dy) << (QUOT_BITS - 1 - k);
         vld_in[k]  = sv;
         denx_in[k] = dx;
         deny_in[k] = dy;
         remx_in[k] = (rx >= tx) ? rx - tx : rx;
         remy_in[k] = (ry >= ty) ? ry - ty : ry;
         qx_in[k]   = {qx[QUOT_BITS-2:0], rx >= tx};
         qy_in[k]   = {qy[QUOT_BITS-2:0], ry >= ty};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QUOT_BITS; k++) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_in[k];
         end
         if (advance) begin
            remx_ff[k] <= remx_in[k];
            remy_ff[k] <= remy_in[k];
            denx_ff[k] <= denx_in[k];
            deny_ff[k] <= deny_in[k];
            qx_ff[k]   <= qx_in[k];
            qy_ff[k]   <= qy_in[k];
         end
      end
   end

   always_comb begin
      col = 9'(cfg.screen_left) + 9'(qx_ff[QUOT_BITS-1]);
      row = 8'(cfg.screen_bottom) - 8'(qy_ff[QUOT_BITS-1]);
      rsp_valid_in = vld_ff[QUOT_BITS-1] && (col < 9'(SCREEN_WIDTH))
                     && !row[7] && (row < 8'(SCREEN_HEIGHT));
      rsp_in.pixel_col = col[6:0];
      rsp_in.pixel_row = row[5:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/core/isometric_point_to_pixel_top.sv
// Top level of the isometric point-to-pixel mapper: configuration registers,
// front end, queue and back end. Depends on ipp_pkg, ipp_front, ipp_fifo, ipp_back.
//
// Each accepted sample (x, y, z in signed Q8.8, plus an error flag) is
// projected isometrically, checked against the view window and mapped into
// the screen rectangle; it yields one pixel (column, row with row 0 at the
// top) or nothing. One sample is taken per cycle while the output is not
// stalled; a sample's pixel passes through 3 front stages, a queue write,
// 7 divider stages and the output register, with the first front stage
// loading on the accepting edge. The seven divider stages give one
// quotient bit each. Write the
// configuration only while the block is empty.
module isometric_point_to_pixel_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ipp_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ipp_pkg::rsp_type rsp_payload,
   input  logic             csr_write_enable,
   input  logic [7:0]       csr_index,
   input  logic [15:0]      csr_write_data
);
   import ipp_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            accept;
   logic [1:0]      inflight;
   logic            push, pop, empty;
   work_type        work, head;
   fifo_status_type fstat;

   // register decode; writes beyond the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_VIEW_MIN_X:    cfg_in.view_min_x    = csr_write_data;
            REG_VIEW_MAX_X:    cfg_in.view_max_x    = csr_write_data;
            REG_VIEW_MIN_Y:    cfg_in.view_min_y    = csr_write_data;
            REG_VIEW_MAX_Y:    cfg_in.view_max_y    = csr_write_data;
            REG_SCREEN_LEFT:   cfg_in.screen_left   = csr_write_data[6:0];
            REG_SCREEN_TOP:    cfg_in.screen_top    = csr_write_data[5:0];
            REG_SCREEN_RIGHT:  cfg_in.screen_right  = csr_write_data[6:0];
            REG_SCREEN_BOTTOM: cfg_in.screen_bottom = csr_write_data[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.view_min_x    <= -16'sd640;
         cfg_ff.view_max_x    <= 16'sd640;
         cfg_ff.view_min_y    <= -16'sd320;
         cfg_ff.view_max_y    <= 16'sd320;
         cfg_ff.screen_left   <= 7'd0;
         cfg_ff.screen_top    <= 6'd0;
         cfg_ff.screen_right  <= 7'd127;
         cfg_ff.screen_bottom <= 6'd63;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // hold the input once queued plus in-flight samples reach one below the queue depth
   assign req_stall = (5'(fstat.count) + 5'(inflight)) >= 5'(FIFO_DEPTH - 1);
   assign accept    = req_valid && !req_stall;

   ipp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_payload),
      .cfg      (cfg_ff),
      .inflight (inflight),
      .push     (push),
      .work     (work)
   );

   ipp_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (work),
      .pop     (pop),
      .rd_data (head),
      .empty   (empty),
      .status  (fstat)
   );

   ipp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .empty       (empty),
      .head        (head),
      .cfg         (cfg_ff),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      fstat.count <= 4'(FIFO_DEPTH))
      else $error("queue count over depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (fstat.push && !fstat.pop) |-> (fstat.count < 4'(FIFO_DEPTH)))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      fstat.pop |-> (fstat.count != 4'd0))
      else $error("pop from empty queue");
`endif

endmodule

>>> test/isometric_point_to_pixel_top_test.sv
// Self-checking testbench for isometric_point_to_pixel_top: streams surface
// samples through several view and screen settings and checks every pixel
// against an in-bench projection model. Depends on ipp_pkg and the RTL.
module isometric_point_to_pixel_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ipp_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 24;   // pipeline depth plus margin
   localparam int IDLE_PCT     = 18;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic    csr_write_enable = 1'b0;
   logic [7:0]  csr_index = '0;
   logic [15:0] csr_write_data = '0;

   isometric_point_to_pixel_top i_dut (
      .clock, .reset, .req_valid, .req_stall, .req_payload,
      .rsp_valid, .rsp_stall, .rsp_payload,
      .csr_write_enable, .csr_index, .csr_write_data
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the configuration registers
   cfg_type view_cfg;
   req_type pending_samples[$];
   rsp_type expected_pixels[$];
   int      cycle = 0;
   int      errors = 0;
   int      samples_taken = 0;
   int      pixels_seen = 0;
   int      settings_run = 0;
   int      hold_left = 0;

   // Calm stretch: no idling on either side
   function automatic logic calm();
      return cycle >= 1000 && cycle < 2500;
   endfunction

   // Project one sample and map it onto the screen; return 1 if a pixel results
   function automatic logic map_sample(input req_type s, input cfg_type c,
                                       output rsp_type px);
      longint x, y, z, u, v, lo_x, hi_x, lo_y, hi_y;
      longint sw, sh, den_x, den_y, num_x, num_y, col, row;
      px = '0;
      if (s.eval_error) return 1'b0;
      x = longint'(s.point_x);
      y = longint'(s.point_y);
      z = longint'(s.point_z);
      u = 64'sd46341 * (x - y);
      v = 64'sd53510 * z - 64'sd26755 * (x + y);
      lo_x = longint'(c.view_min_x) * 65536;
      hi_x = longint'(c.view_max_x) * 65536;
      lo_y = longint'(c.view_min_y) * 65536;
      hi_y = longint'(c.view_max_y) * 65536;
      if (u < lo_x || u > hi_x || v < lo_y || v > hi_y) return 1'b0;
      if (hi_x == lo_x || hi_y == lo_y) return 1'b0;
      sw = longint'(c.screen_right) - longint'(c.screen_left);
      sh = longint'(c.screen_bottom) - longint'(c.screen_top);
      if (sw < 0 || sh < 0) return 1'b0;
      den_x = hi_x - lo_x;
      den_y = hi_y - lo_y;
      num_x = (u - lo_x) * sw;
      num_y = (v - lo_y) * sh;
      if (num_x > sw * den_x || num_y > sh * den_y) return 1'b0;
      col = longint'(c.screen_left) + num_x / den_x;
      row = longint'(c.screen_bottom) - (num_y + den_y - 1) / den_y;
      if (col < 0 || col >= SCREEN_WIDTH || row < 0 || row >= SCREEN_HEIGHT)
         return 1'b0;
      px.pixel_col = col[6:0];
      px.pixel_row = row[5:0];
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // Driver: offer queued samples, hold a stalled transaction unchanged
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_samples.size() != 0 &&
             (calm() || $urandom_range(99) >= IDLE_PCT)) begin
            req_payload <= pending_samples.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off so the block fills up and stalls its input
   always @(posedge clock) begin
      if (cycle == 200) hold_left <= 300;
      else if (hold_left > 0) hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= (hold_left > 0) || (!calm() && $urandom_range(99) < IDLE_PCT);
   end

   // Monitor: predict on accepted samples, check accepted pixels
   always @(posedge clock) begin
      rsp_type px, want;
      cycle <= cycle + 1;
      if (!reset && req_valid && !req_stall) begin
         samples_taken++;
         if (map_sample(req_payload, view_cfg, px)) expected_pixels.push_back(px);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         pixels_seen++;
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel col=%0d row=%0d",
                                      rsp_payload.pixel_col, rsp_payload.pixel_row));
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_payload.pixel_col !== want.pixel_col)
               report_mismatch($sformatf("pixel_col got %0d want %0d",
                                         rsp_payload.pixel_col, want.pixel_col));
            if (rsp_payload.pixel_row !== want.pixel_row)
               report_mismatch($sformatf("pixel_row got %0d want %0d",
                                         rsp_payload.pixel_row, want.pixel_row));
         end
      end
      if (cycle > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Write one register and mirror it, keeping only the register's width
   task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         REG_VIEW_MIN_X:    view_cfg.view_min_x    = data;
         REG_VIEW_MAX_X:    view_cfg.view_max_x    = data;
         REG_VIEW_MIN_Y:    view_cfg.view_min_y    = data;
         REG_VIEW_MAX_Y:    view_cfg.view_max_y    = data;
         REG_SCREEN_LEFT:   view_cfg.screen_left   = data[6:0];
         REG_SCREEN_TOP:    view_cfg.screen_top    = data[5:0];
         REG_SCREEN_RIGHT:  view_cfg.screen_right  = data[6:0];
         REG_SCREEN_BOTTOM: view_cfg.screen_bottom = data[5:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_view(input int min_x, max_x, min_y, max_y,
                           input int left, top, right, bottom);
      write_reg(REG_VIEW_MIN_X, 16'(min_x));
      write_reg(REG_VIEW_MAX_X, 16'(max_x));
      write_reg(REG_VIEW_MIN_Y, 16'(min_y));
      write_reg(REG_VIEW_MAX_Y, 16'(max_y));
      write_reg(REG_SCREEN_LEFT, 16'(left));
      write_reg(REG_SCREEN_TOP, 16'(top));
      write_reg(REG_SCREEN_RIGHT, 16'(right));
      write_reg(REG_SCREEN_BOTTOM, 16'(bottom));
      settings_run++;
   endtask

   function automatic req_type make_sample(input int x, y, z, input logic flag);
      req_type s;
      s.point_x = 16'(x);
      s.point_y = 16'(y);
      s.point_z = 16'(z);
      s.eval_error = flag;
      return s;
   endfunction

   // Mostly samples near the window so pixels come out, plus full-range noise
   task automatic queue_random(input int count);
      int reach;
      int mx;
      mx = view_cfg.view_min_x < 0 ? -view_cfg.view_min_x : view_cfg.view_min_x;
      reach = view_cfg.view_max_x < 0 ? -view_cfg.view_max_x : view_cfg.view_max_x;
      if (mx > reach) reach = mx;
      reach = reach + 64;
      if (reach > 32767) reach = 32767;
      repeat (count) begin
         if ($urandom_range(99) < 75)
            pending_samples.push_back(make_sample(
               $urandom_range(2 * reach) - reach, $urandom_range(2 * reach) - reach,
               $urandom_range(2 * reach) - reach, $urandom_range(99) < 8));
         else
            pending_samples.push_back(make_sample($urandom, $urandom, $urandom,
                                                  1'($urandom_range(1))));
      end
   endtask

   // Let queued samples go out, then wait for every pixel and the pipeline tail
   task automatic drain();
      while (pending_samples.size() != 0 || req_valid) @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      view_cfg = '{view_min_x: -16'sd640, view_max_x: 16'sd640,
                   view_min_y: -16'sd320, view_max_y: 16'sd320,
                   screen_left: 7'd0, screen_top: 6'd0,
                   screen_right: 7'd127, screen_bottom: 6'd63};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: field extremes, flagged samples, window edges
      pending_samples.push_back(make_sample(0, 0, 0, 1'b0));
      pending_samples.push_back(make_sample(0, 0, 0, 1'b1));
      pending_samples.push_back(make_sample(32767, -32768, 32767, 1'b0));
      pending_samples.push_back(make_sample(-32768, 32767, -32768, 1'b0));
      pending_samples.push_back(make_sample(-32768, -32768, -32768, 1'b1));
      pending_samples.push_back(make_sample(32767, 32767, 32767, 1'b0));
      pending_samples.push_back(make_sample(452, -453, 0, 1'b0));
      pending_samples.push_back(make_sample(-452, 452, 0, 1'b0));
      pending_samples.push_back(make_sample(0, 0, 391, 1'b0));
      pending_samples.push_back(make_sample(0, 0, -391, 1'b0));
      pending_samples.push_back(make_sample(100, 100, 100, 1'b0));
      queue_random(260);
      drain();

      // Widest window and full screen
      set_view(-32768, 32767, -32768, 32767, 0, 0, 127, 63);
      pending_samples.push_back(make_sample(32767, -32768, 0, 1'b0));
      pending_samples.push_back(make_sample(0, 0, 32767, 1'b0));
      pending_samples.push_back(make_sample(-32768, -32768, -32768, 1'b0));
      queue_random(180);
      drain();

      // Window edge at zero: samples with x == y sit on it
      set_view(0, 900, 0, 300, 10, 5, 100, 50);
      pending_samples.push_back(make_sample(77, 77, 150, 1'b0));
      pending_samples.push_back(make_sample(-5, -5, 0, 1'b0));
      queue_random(120);
      drain();

      // Zero-width window: nothing passes
      set_view(200, 200, -320, 320, 0, 0, 127, 63);
      queue_random(80);
      drain();

      // Inverted window
      set_view(-640, 640, 320, -320, 0, 0, 127, 63);
      queue_random(80);
      drain();

      // Inverted screen rectangle
      set_view(-640, 640, -320, 320, 90, 40, 20, 10);
      queue_random(80);
      drain();

      // Single-pixel rectangle at the far corner
      set_view(-640, 640, -320, 320, 127, 63, 127, 63);
      queue_random(80);
      drain();

      // Out-of-range index is ignored; oversize data is truncated
      write_reg(8'd8, 16'h1234);
      write_reg(8'd255, 16'hFFFF);
      write_reg(REG_SCREEN_LEFT, 16'hFF83);
      write_reg(REG_SCREEN_BOTTOM, 16'hFFFF);
      write_reg(REG_SCREEN_TOP, 16'h0040);
      write_reg(REG_SCREEN_RIGHT, 16'h00FF);
      queue_random(80);
      drain();

      // Random settings, mostly well formed
      repeat (5) begin
         int lo_x, lo_y, l, t;
         lo_x = $urandom_range(4000) - 3000;
         lo_y = $urandom_range(4000) - 3000;
         l = $urandom_range(100);
         t = $urandom_range(50);
         set_view(lo_x, lo_x + $urandom_range(6000), lo_y, lo_y + $urandom_range(6000),
                  l, t, l + $urandom_range(127 - l), t + $urandom_range(63 - t));
         queue_random(110);
         drain();
      end

      $display("covered %0d samples and %0d pixels over %0d view settings",
               samples_taken, pixels_seen, settings_run);
      $display("settings included reset values, extreme, empty and inverted windows");
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
